// File: src/csub_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csub_pkg;

    // Default depth of the line store, in pixels.
    localparam int MAX_WIDTH_DEF = 4096;

    localparam int PIX_W       = 8;
    localparam int FW_W        = 13;
    localparam int FH_W        = 16;
    localparam int ROW_W       = 16;
    localparam int GEOM_W      = 17;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Per-pixel control decoded from the raster position.
    typedef struct packed {
        logic store;
        logic hold;
        logic emit;
        logic frame_last;
    } pix_ctrl_t;

    // One subsampled result.
    typedef struct packed {
        logic             frame_last;
        logic [PIX_W-1:0] cg;
        logic [PIX_W-1:0] co;
    } sub_item_t;

    // Unsigned byte average that rounds up: (a + b + 1) >> 1.
    function automatic logic [PIX_W-1:0] avg_up(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
        logic [PIX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
        return sum[PIX_W:1];
    endfunction

endpackage

`default_nettype wire

// File: src/chroma_420_box_subsampler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// 4:2:0 chroma subsampler for the Co and Cg planes. Pixel pairs enter on the
// slave stream in raster order over the padded frame (width rounded up to a
// multiple of 8 and capped at MAX_WIDTH, height rounded up to even); an item
// that completes a 2x2 block passes through the averaging stage register into
// the output queue and is offered on the master stream from there, with tlast
// set on the last block of the frame. The rate is one item per cycle unless
// the input stalls, set by the single-port line store, which each item uses
// exactly once: a write on even rows, a read on odd rows. A two-entry output
// queue lets the input keep flowing while a result waits; the input stalls
// when that queue is full, or holds one result while the averaging stage
// produces another. The line store needs no clearing after reset, so the
// block is ready as soon as reset is released. The user must write geometry
// through the configuration port only while the block is idle, which the
// block does not enforce. Index 0 is frame_width and index 1 is frame_height.
module chroma_420_box_subsampler_top #(
    parameter int MAX_WIDTH = csub_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [csub_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [csub_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0 up: co_pixel[7:0], cg_pixel[15:8].
    input  wire logic [15:0]                      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // Fields from bit 0 up: co_sub[7:0], cg_sub[15:8].
    output logic [15:0]                           m_axis_tdata,
    // frame_last: set on the final result of the frame.
    output logic                                  m_axis_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                   s_accept;
    logic [COL_W-1:0]       pixel_x;
    csub_pkg::pix_ctrl_t    ctrl;
    logic [15:0]            store_rdata;
    logic                   s1_valid;
    logic                   push;
    csub_pkg::sub_item_t    push_item;
    logic                   pop;
    csub_pkg::sub_item_t    head_item;
    logic [1:0]             fifo_count;

    // The item in the averaging stage is counted against the queue only if
    // it will produce a result.
    assign s_axis_tready = (fifo_count == 2'd0) || ((fifo_count == 2'd1) && !push);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    csub_addr_gen #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (s_accept),
        .pixel_x   (pixel_x),
        .ctrl      (ctrl)
    );

    // Even rows write the pair, odd rows read the pair stored above. A write
    // and a later read of the same column are a whole row apart, so no
    // forwarding is needed.
    csub_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .clk   (clk),
        .en    (s_accept),
        .we    (ctrl.store),
        .addr  (pixel_x),
        .wdata (s_axis_tdata),
        .rdata (store_rdata)
    );

    csub_average u_average (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .ctrl_in     (ctrl),
        .co_in       (s_axis_tdata[7:0]),
        .cg_in       (s_axis_tdata[15:8]),
        .store_rdata (store_rdata),
        .s1_valid    (s1_valid),
        .push        (push),
        .push_item   (push_item)
    );

    csub_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (m_axis_tvalid),
        .head_item  (head_item),
        .count      (fifo_count)
    );

    assign m_axis_tdata = {head_item.cg, head_item.co};
    assign m_axis_tlast = head_item.frame_last;

    // The queue never holds more than its two entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count != 2'd3)
        else $error("output queue overflow");

    // A result never arrives at a full queue unless one leaves in that cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && fifo_count == 2'd2) |-> pop)
        else $error("result pushed into a full queue");

    // The averaging stage never stalls: every accepted item is in it next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> s1_valid)
        else $error("accepted item lost before the averaging stage");

    // An empty queue always leaves the input open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_count == 2'd0) |-> s_axis_tready)
        else $error("input stalled with an empty output queue");

endmodule

`default_nettype wire

// File: src/csub_line_store.sv
`timescale 1ns / 1ps
`default_nettype none

module csub_line_store #(
    parameter int DEPTH  = csub_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(csub_pkg::MAX_WIDTH_DEF)
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic                        we,
    input  wire logic [ADDR_W-1:0]           addr,
    input  wire logic [2*csub_pkg::PIX_W-1:0] wdata,
    output logic      [2*csub_pkg::PIX_W-1:0] rdata
);

    logic [2*csub_pkg::PIX_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem_reg[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata <= mem_reg[addr];
        end
    end

endmodule

`default_nettype wire

// File: src/csub_addr_gen.sv
`timescale 1ns / 1ps
`default_nettype none

module csub_addr_gen #(
    parameter int MAX_WIDTH = csub_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [csub_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [csub_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              accept,
    output logic      [COL_W-1:0]                  pixel_x,
    output csub_pkg::pix_ctrl_t                    ctrl
);

    localparam int PW_W = $clog2(MAX_WIDTH + 1);
    localparam int GW   = csub_pkg::GEOM_W;

    logic [PW_W-1:0]            pw_reg, pw_next;
    logic [GW-1:0]              ph_reg, ph_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [csub_pkg::ROW_W-1:0] row_reg, row_next;

    logic [GW-1:0] fw_ext, fw_up, fh_ext, fh_up;
    logic [GW-1:0] pw_ext, col_ext, row_inc, x, y, xn, yn;

    // Padded geometry is worked out once, when the register is written.
    always_comb
    begin
        pw_next = pw_reg;
        ph_next = ph_reg;
        fw_ext  = GW'(cfg_data[csub_pkg::FW_W-1:0]);
        fw_up   = (fw_ext + GW'(7)) & ~GW'(7);
        fh_ext  = GW'(cfg_data[csub_pkg::FH_W-1:0]);
        fh_up   = (fh_ext + GW'(1)) & ~GW'(1);
        if (cfg_we)
        begin
            case (cfg_index)
                csub_pkg::REG_FRAME_WIDTH:
                begin
                    if (fw_up == '0)
                        pw_next = PW_W'(8);
                    else if (fw_up > GW'(MAX_WIDTH))
                        pw_next = PW_W'(MAX_WIDTH);
                    else
                        pw_next = PW_W'(fw_up);
                end
                csub_pkg::REG_FRAME_HEIGHT:
                begin
                    if (fh_up == '0)
                        ph_next = GW'(2);
                    else
                        ph_next = fh_up;
                end
                default:
                begin
                    pw_next = pw_reg;
                end
            endcase
        end
    end

    // Raster position of the current pixel, then the position after it.
    always_comb
    begin
        pw_ext  = GW'(pw_reg);
        col_ext = GW'(col_reg);
        if (col_ext >= pw_ext)
        begin
            x       = '0;
            row_inc = GW'(row_reg) + GW'(1);
        end
        else
        begin
            x       = col_ext;
            row_inc = GW'(row_reg);
        end
        y  = (row_inc >= ph_reg) ? '0 : row_inc;
        xn = x + GW'(1);
        yn = y + GW'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (xn >= pw_ext)
            begin
                col_next = '0;
                row_next = (yn >= ph_reg) ? '0 : yn[csub_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = xn[COL_W-1:0];
                row_next = y[csub_pkg::ROW_W-1:0];
            end
        end

        pixel_x          = x[COL_W-1:0];
        ctrl.store       = !y[0];
        ctrl.hold        = y[0] && !x[0];
        ctrl.emit        = y[0] && x[0];
        ctrl.frame_last  = (xn == pw_ext) && (yn == ph_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg  <= PW_W'(8);
            ph_reg  <= GW'(2);
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            pw_reg  <= pw_next;
            ph_reg  <= ph_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: src/csub_average.sv
`timescale 1ns / 1ps
`default_nettype none

module csub_average (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             accept,
    input  wire csub_pkg::pix_ctrl_t              ctrl_in,
    input  wire logic [csub_pkg::PIX_W-1:0]       co_in,
    input  wire logic [csub_pkg::PIX_W-1:0]       cg_in,
    input  wire logic [2*csub_pkg::PIX_W-1:0]     store_rdata,
    output logic                                  s1_valid,
    output logic                                  push,
    output csub_pkg::sub_item_t                   push_item
);

    logic                         valid_reg, valid_next;
    csub_pkg::pix_ctrl_t          ctrl_reg;
    logic [csub_pkg::PIX_W-1:0]   co_reg, cg_reg;
    logic [csub_pkg::PIX_W-1:0]   held_co_reg, held_co_next;
    logic [csub_pkg::PIX_W-1:0]   held_cg_reg, held_cg_next;
    logic [csub_pkg::PIX_W-1:0]   v_co, v_cg;

    // The line store data for the pixel in this stage arrives now.
    always_comb
    begin
        valid_next   = accept;
        v_co         = csub_pkg::avg_up(store_rdata[csub_pkg::PIX_W-1:0], co_reg);
        v_cg         = csub_pkg::avg_up(store_rdata[2*csub_pkg::PIX_W-1:csub_pkg::PIX_W],
                                        cg_reg);
        held_co_next = held_co_reg;
        held_cg_next = held_cg_reg;
        if (valid_reg && ctrl_reg.hold)
        begin
            held_co_next = v_co;
            held_cg_next = v_cg;
        end
        push                 = valid_reg && ctrl_reg.emit;
        push_item.co         = csub_pkg::avg_up(held_co_reg, v_co);
        push_item.cg         = csub_pkg::avg_up(held_cg_reg, v_cg);
        push_item.frame_last = ctrl_reg.frame_last;
        s1_valid             = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            held_co_reg <= '0;
            held_cg_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            held_co_reg <= held_co_next;
            held_cg_reg <= held_cg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctrl_reg <= ctrl_in;
            co_reg   <= co_in;
            cg_reg   <= cg_in;
        end
    end

endmodule

`default_nettype wire

// File: src/csub_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module csub_out_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire csub_pkg::sub_item_t push_item,
    input  wire logic                pop,
    output logic                     head_valid,
    output csub_pkg::sub_item_t      head_item,
    output logic [1:0]               count
);

    csub_pkg::sub_item_t entry_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        head_valid  = (count_reg != 2'd0);
        head_item   = entry_reg[rd_ptr_reg];
        count       = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire
